@@ rtl/core/wsd_pkg.sv @@
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants for the websocket frame deframer: parser
// phases, opcodes, header length codes and result kinds.
// ----------------------------------------------------------------------------
package wsd_pkg;

	// default width of the payload length counter
	localparam int LENGTH_BITS_DEF = 64;

	// parser phases, one-hot
	typedef enum logic [4:0] {
		PH_HDR0   = 5'b00001,
		PH_HDR1   = 5'b00010,
		PH_EXTLEN = 5'b00100,
		PH_KEY    = 5'b01000,
		PH_DATA   = 5'b10000
	} phase_t;

	// frame opcodes
	localparam logic [3:0] OP_CONT  = 4'h0;
	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_BIN   = 4'h2;
	localparam logic [3:0] OP_CLOSE = 4'h8;

	// 7-bit length codes that announce an extended length
	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;

	// bytes still due in a header part, minus one
	localparam logic [2:0] HBC_EXT16 = 3'd1;
	localparam logic [2:0] HBC_EXT64 = 3'd7;
	localparam logic [2:0] HBC_KEY   = 3'd3;

	// result kinds
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_EMPTY   = 2'd1;
	localparam logic [1:0] KIND_CLOSE   = 2'd2;

endpackage

@@ rtl/core/websocket_frame_deframer_core.sv @@
// ----------------------------------------------------------------------------
// websocket_frame_deframer_core
// Receive-side frame parser for one websocket session: header decode,
// payload unmasking of text frames, message-end and close events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall / in_byte, one session byte per beat,
//   taken at an edge where in_valid is high and in_stall is low.
//   Output channel: out_valid / out_stall with out_kind, out_byte, msg_end.
//   Each input beat gives at most one output beat: an unmasked text payload
//   byte, an empty-final-text-frame event or a close event.
//   An accepted byte sits in the input register and is then parsed into
//   the output register, from which its result can be taken.
//   Throughput is one byte per cycle while in_stall is low; the parser
//   state is updated once per byte by the logic between the two registers.
//   When out_stall holds a pending result, a byte that produces no result
//   still moves on; a byte that would produce one waits in the input
//   register and in_stall rises until the output register frees up.
//   Reset (arst_n low) empties both registers and returns the parser to the
//   first header byte with no open text message.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_core #(
	parameter int LengthBits = wsd_pkg::LENGTH_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] out_kind,
	output logic [7:0] out_byte,
	output logic       msg_end
);

	localparam logic [LengthBits-1:0] LenOne  = LengthBits'(1);
	localparam logic [LengthBits-1:0] LenOnes = '1;

	// input register
	logic       in_valid_s1;
	logic [7:0] in_byte_s1;

	// parser state
	wsd_pkg::phase_t        phase_q,    phase_n;
	logic                   fin_q,      fin_n;
	logic [3:0]             opcode_q,   opcode_n;
	logic                   masked_q,   masked_n;
	logic [LengthBits-1:0]  rem_q,      rem_n;
	logic [2:0]             hbc_q,      hbc_n;
	logic [31:0]            key_q,      key_n;
	logic [1:0]             key_idx_q,  key_idx_n;
	logic                   msg_text_q, msg_text_n;
	logic                   frame_text_q, frame_text_n;

	// output register
	logic       out_valid_q;
	logic [1:0] out_kind_q;
	logic [7:0] out_byte_q;
	logic       msg_end_q;

	// result of the byte in the input register
	logic       res_vld;
	logic [1:0] res_kind;
	logic [7:0] res_byte;
	logic       res_end;

	logic       do_after_len;
	logic       do_hdr_done;
	logic       last;
	logic [7:0] key_byte;
	logic       s1_adv;

	always_comb begin
		case (key_idx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_n      = phase_q;
		fin_n        = fin_q;
		opcode_n     = opcode_q;
		masked_n     = masked_q;
		rem_n        = rem_q;
		hbc_n        = hbc_q;
		key_n        = key_q;
		key_idx_n    = key_idx_q;
		msg_text_n   = msg_text_q;
		frame_text_n = frame_text_q;
		res_vld      = 1'b0;
		res_kind     = wsd_pkg::KIND_PAYLOAD;
		res_byte     = 8'h00;
		res_end      = 1'b0;
		do_after_len = 1'b0;
		do_hdr_done  = 1'b0;
		last         = (rem_q == LenOne);

		case (phase_q)
			wsd_pkg::PH_HDR1: begin
				masked_n = in_byte_s1[7];
				rem_n    = '0;
				if (in_byte_s1[6:0] == wsd_pkg::LEN7_EXT16) begin
					hbc_n   = wsd_pkg::HBC_EXT16;
					phase_n = wsd_pkg::PH_EXTLEN;
				end else if (in_byte_s1[6:0] == wsd_pkg::LEN7_EXT64) begin
					hbc_n   = wsd_pkg::HBC_EXT64;
					phase_n = wsd_pkg::PH_EXTLEN;
				end else begin
					rem_n        = LengthBits'(in_byte_s1[6:0]);
					do_after_len = 1'b1;
				end
			end
			wsd_pkg::PH_EXTLEN: begin
				// saturate once the next shift would overflow the counter
				if (|rem_q[LengthBits-1 -: 8])
					rem_n = LenOnes;
				else
					rem_n = {rem_q[LengthBits-9:0], in_byte_s1};
				if (hbc_q == 3'd0)
					do_after_len = 1'b1;
				else
					hbc_n = hbc_q - 3'd1;
			end
			wsd_pkg::PH_KEY: begin
				key_n = {key_q[23:0], in_byte_s1};
				if (hbc_q == 3'd0)
					do_hdr_done = 1'b1;
				else
					hbc_n = hbc_q - 3'd1;
			end
			wsd_pkg::PH_DATA: begin
				rem_n = rem_q - LenOne;
				if (frame_text_q) begin
					res_vld  = 1'b1;
					res_kind = wsd_pkg::KIND_PAYLOAD;
					res_byte = masked_q ? (in_byte_s1 ^ key_byte) : in_byte_s1;
					res_end  = last && fin_q;
				end else if (last && opcode_q == wsd_pkg::OP_CLOSE) begin
					res_vld  = 1'b1;
					res_kind = wsd_pkg::KIND_CLOSE;
				end
				key_idx_n = key_idx_q + 2'd1;
				if (last)
					phase_n = wsd_pkg::PH_HDR0;
			end
			default: begin
				fin_n    = in_byte_s1[7];
				opcode_n = in_byte_s1[3:0];
				if (in_byte_s1[3:0] == wsd_pkg::OP_TEXT)
					frame_text_n = 1'b1;
				else if (in_byte_s1[3:0] == wsd_pkg::OP_CONT)
					frame_text_n = msg_text_q;
				else
					frame_text_n = 1'b0;
				// only data frames touch the open-message flag
				if (in_byte_s1[3:0] == wsd_pkg::OP_TEXT || in_byte_s1[3:0] == wsd_pkg::OP_CONT
						|| in_byte_s1[3:0] == wsd_pkg::OP_BIN)
					msg_text_n = frame_text_n && !in_byte_s1[7];
				phase_n = wsd_pkg::PH_HDR1;
			end
		endcase

		if (do_after_len) begin
			if (masked_n) begin
				phase_n = wsd_pkg::PH_KEY;
				hbc_n   = wsd_pkg::HBC_KEY;
				key_n   = '0;
			end else begin
				do_hdr_done = 1'b1;
			end
		end

		if (do_hdr_done) begin
			key_idx_n = 2'd0;
			if (rem_n != '0) begin
				phase_n = wsd_pkg::PH_DATA;
			end else begin
				phase_n = wsd_pkg::PH_HDR0;
				if (frame_text_q && fin_q) begin
					res_vld  = 1'b1;
					res_kind = wsd_pkg::KIND_EMPTY;
					res_end  = 1'b1;
				end else if (opcode_q == wsd_pkg::OP_CLOSE) begin
					res_vld  = 1'b1;
					res_kind = wsd_pkg::KIND_CLOSE;
				end
			end
		end
	end

	// a byte with a result waits while the output register is held
	assign s1_adv   = in_valid_s1 && !(res_vld && out_valid_q && out_stall);
	assign in_stall = in_valid_s1 && !s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			in_byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= wsd_pkg::PH_HDR0;
			fin_q        <= 1'b0;
			opcode_q     <= wsd_pkg::OP_CONT;
			masked_q     <= 1'b0;
			rem_q        <= '0;
			hbc_q        <= 3'd0;
			key_q        <= '0;
			key_idx_q    <= 2'd0;
			msg_text_q   <= 1'b0;
			frame_text_q <= 1'b0;
		end else if (s1_adv) begin
			phase_q      <= phase_n;
			fin_q        <= fin_n;
			opcode_q     <= opcode_n;
			masked_q     <= masked_n;
			rem_q        <= rem_n;
			hbc_q        <= hbc_n;
			key_q        <= key_n;
			key_idx_q    <= key_idx_n;
			msg_text_q   <= msg_text_n;
			frame_text_q <= frame_text_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && res_vld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && res_vld) begin
			out_kind_q <= res_kind;
			out_byte_q <= res_byte;
			msg_end_q  <= res_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_byte  = out_byte_q;
	assign msg_end   = msg_end_q;

endmodule

@@ rtl/core/wsd_checker.sv @@
// ----------------------------------------------------------------------------
// wsd_core_sva
// Port-level checks on the deframer's outputs and in_stall, bound to the core.
// ----------------------------------------------------------------------------
module wsd_core_sva (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] out_kind,
	input logic [7:0] out_byte,
	input logic       msg_end
);

	// an empty-frame event always ends the message
	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == wsd_pkg::KIND_EMPTY |-> msg_end)
		else $error("empty frame event without msg_end");

	// a close event never ends a text message
	a_close_no_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == wsd_pkg::KIND_CLOSE |-> !msg_end)
		else $error("close event with msg_end");

	// only payload beats carry data
	a_event_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != wsd_pkg::KIND_PAYLOAD |-> out_byte == 8'h00)
		else $error("event beat with nonzero byte");

	// input stall is only raised while a result is held at the output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held output beat");

	// a held output beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_byte)
			&& $stable(msg_end))
		else $error("held output beat changed");

endmodule

bind websocket_frame_deframer_core wsd_core_sva u_wsd_core_sva (.*);
